### design/fvds_pkg.sv
// ----------------------------------------------------------------------------
// fvds_pkg
// Shared types, digit codes and screen phase codes for the four-digit
// display sequencer, plus the 0..999 to three-digit conversion.
// ----------------------------------------------------------------------------
package fvds_pkg;

	typedef logic [4:0] digit_t;
	typedef logic [1:0] phase_t;

	localparam logic FUNC_UPDATE  = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

	localparam digit_t CODE_U     = 5'd20;
	localparam digit_t CODE_F     = 5'd21;
	localparam digit_t CODE_DASH  = 5'd22;
	localparam digit_t CODE_POINT = 5'd10;
	localparam digit_t CODE_THREE = 5'd3;

	localparam phase_t PH_BANNER = 2'd0;
	localparam phase_t PH_FREQ   = 2'd1;
	localparam phase_t PH_VOLT   = 2'd2;

	localparam logic [9:0] DISP_MAX = 10'd999;

	localparam logic [1:0] REG_BANNER_HOLD = 2'd0;
	localparam logic [1:0] REG_FREQ_HOLD   = 2'd1;
	localparam logic [1:0] REG_VOLT_HOLD   = 2'd2;

	localparam logic [15:0] BANNER_HOLD_RST = 16'd200;
	localparam logic [15:0] FREQ_HOLD_RST   = 16'd400;
	localparam logic [15:0] VOLT_HOLD_RST   = 16'd400;

	// splits 0..999 into {hundreds, tens, ones} by reciprocal multiplication
	function automatic logic [11:0] bcd3(input logic [9:0] v);
		logic [15:0] hp;
		logic [3:0]  h;
		logic [9:0]  hx;
		logic [6:0]  r;
		logic [13:0] tp;
		logic [3:0]  t;
		logic [6:0]  tx;
		logic [3:0]  o;
		hp = {6'd0, v} * 16'd41;
		h  = hp[15:12];
		hx = 10'(h) * 10'd100;
		r  = 7'(v - hx);
		tp = {7'd0, r} * 14'd103;
		t  = tp[13:10];
		tx = 7'(t) * 7'd10;
		o  = 4'(r - tx);
		return {h, t, o};
	endfunction

endpackage

### design/freq_volt_display_sequencer.sv
// ----------------------------------------------------------------------------
// freq_volt_display_sequencer
// Steps a four-digit display through banner, frequency and voltage screens,
// each held for a programmable number of ticks.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | moves
//  ---------+-------------------------------------------+----------------------
//  in       | in_valid in_ready func tick_now           | one update or restart
//           | freq_value volt_tenths                    |
//  out      | out_valid out_ready digit_code_0..3       | one screen per update
//  cfg      | cfg_valid cfg_ready cfg_index cfg_data    | one hold register
//
//  one item per clock unless out_ready stalls; a screen is registered in
//  the input register, then the result register; each holds one item, so the
//  next item is taken while a finished screen waits for out_ready
//  a restart leaves no result and only moves the phase state
//  arst_n clears phase, start tick, valid flags and loads the hold defaults
//  cfg_ready is always high
// ----------------------------------------------------------------------------
module freq_volt_display_sequencer
	import fvds_pkg::*;
#(
	parameter int TICK_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [31:0] tick_now,
	input  logic signed [15:0] freq_value,
	input  logic [15:0] volt_tenths,
	output logic        out_valid,
	input  logic        out_ready,
	output digit_t      digit_code_0,
	output digit_t      digit_code_1,
	output digit_t      digit_code_2,
	output digit_t      digit_code_3,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CMP_W = (TICK_BITS > 16) ? TICK_BITS : 16;

	logic [15:0] banner_hold_q, freq_hold_q, volt_hold_q;
	phase_t phase_q;
	logic [TICK_BITS-1:0] start_q;

	logic                 v_s1;
	logic                 func_s1;
	logic [TICK_BITS-1:0] tick_s1;
	logic signed [15:0]   freq_s1;
	logic [15:0]          volt_s1;

	logic   v_s2;
	digit_t d0_s2, d1_s2, d2_s2, d3_s2;

	logic                 adv_s1;
	logic [9:0]           freq_c, volt_c, shown;
	logic [11:0]          bcd;
	digit_t               d0, d1, d2, d3;
	logic [15:0]          hold;
	phase_t               next_phase;
	logic [TICK_BITS-1:0] elapsed;
	logic                 expire;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			banner_hold_q <= BANNER_HOLD_RST;
			freq_hold_q   <= FREQ_HOLD_RST;
			volt_hold_q   <= VOLT_HOLD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BANNER_HOLD: banner_hold_q <= cfg_data;
				REG_FREQ_HOLD:   freq_hold_q   <= cfg_data;
				REG_VOLT_HOLD:   volt_hold_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// a restart needs no room in the result register
	assign adv_s1   = v_s1 && (func_s1 == FUNC_RESTART || !v_s2 || out_ready);
	assign in_ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func;
			tick_s1 <= TICK_BITS'(tick_now);
			freq_s1 <= freq_value;
			volt_s1 <= volt_tenths;
		end
	end

	always_comb begin
		if (freq_s1[15]) begin
			freq_c = 10'd0;
		end else if (freq_s1 > $signed({6'd0, DISP_MAX})) begin
			freq_c = DISP_MAX;
		end else begin
			freq_c = freq_s1[9:0];
		end
		volt_c = (volt_s1 > {6'd0, DISP_MAX}) ? DISP_MAX : volt_s1[9:0];
		shown  = (phase_q == PH_VOLT) ? volt_c : freq_c;
		bcd    = bcd3(shown);

		case (phase_q)
			PH_FREQ: begin
				d0 = CODE_F;
				d1 = {1'b0, bcd[11:8]};
				d2 = {1'b0, bcd[7:4]};
				d3 = {1'b0, bcd[3:0]};
				hold = freq_hold_q;
				next_phase = PH_VOLT;
			end
			PH_VOLT: begin
				d0 = CODE_U;
				d1 = {1'b0, bcd[11:8]};
				d2 = {1'b0, bcd[7:4]} + CODE_POINT;
				d3 = {1'b0, bcd[3:0]};
				hold = volt_hold_q;
				next_phase = PH_FREQ;
			end
			default: begin
				d0 = CODE_DASH;
				d1 = CODE_THREE;
				d2 = CODE_DASH;
				d3 = CODE_DASH;
				hold = banner_hold_q;
				next_phase = PH_FREQ;
			end
		endcase

		// tick difference wraps at the tick width
		elapsed = tick_s1 - start_q;
		expire  = CMP_W'(elapsed) >= CMP_W'(hold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BANNER;
			start_q <= '0;
		end else if (adv_s1) begin
			if (func_s1 == FUNC_RESTART) begin
				phase_q <= PH_BANNER;
				start_q <= tick_s1;
			end else if (expire) begin
				phase_q <= next_phase;
				start_q <= tick_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s1 && func_s1 == FUNC_UPDATE) begin
			v_s2 <= 1'b1;
		end else if (out_ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && func_s1 == FUNC_UPDATE) begin
			d0_s2 <= d0;
			d1_s2 <= d1;
			d2_s2 <= d2;
			d3_s2 <= d3;
		end
	end

	assign out_valid    = v_s2;
	assign digit_code_0 = d0_s2;
	assign digit_code_1 = d1_s2;
	assign digit_code_2 = d2_s2;
	assign digit_code_3 = d3_s2;

endmodule

### design/fvds_checker.sv
// ----------------------------------------------------------------------------
// fvds_checker
// Port-level checks on the screens delivered by the display sequencer.
// ----------------------------------------------------------------------------
module fvds_checker
	import fvds_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   out_valid,
	input logic   out_ready,
	input digit_t digit_code_0,
	input digit_t digit_code_1,
	input digit_t digit_code_2,
	input digit_t digit_code_3
);

	// a stalled screen stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digit_code_0) &&
		$stable(digit_code_1) && $stable(digit_code_2) && $stable(digit_code_3))
		else $error("screen changed while stalled");

	a_lead: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> digit_code_0 == CODE_U || digit_code_0 == CODE_F ||
		digit_code_0 == CODE_DASH)
		else $error("leading digit is not a screen marker");

	a_banner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && digit_code_0 == CODE_DASH |-> digit_code_1 == CODE_THREE &&
		digit_code_2 == CODE_DASH && digit_code_3 == CODE_DASH)
		else $error("banner screen malformed");

	a_freq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && digit_code_0 == CODE_F |-> digit_code_1 < CODE_POINT &&
		digit_code_2 < CODE_POINT && digit_code_3 < CODE_POINT)
		else $error("frequency screen has a bad digit");

	a_volt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && digit_code_0 == CODE_U |-> digit_code_1 < CODE_POINT &&
		digit_code_2 >= CODE_POINT && digit_code_2 < CODE_U &&
		digit_code_3 < CODE_POINT)
		else $error("voltage screen has a bad digit or point");

endmodule

bind freq_volt_display_sequencer fvds_checker u_fvds_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.digit_code_0 (digit_code_0),
	.digit_code_1 (digit_code_1),
	.digit_code_2 (digit_code_2),
	.digit_code_3 (digit_code_3)
);

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frequency/voltage display sequencer. Updates and
// restarts go in over a valid/ready channel in random bursts, screens come
// back under a stalling receiver and are compared digit by digit with a
// behavioral copy of the banner/frequency/voltage phase logic. Hold registers
// are rewritten between test phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fvds_pkg::*;

	typedef struct packed {
		digit_t d0;
		digit_t d1;
		digit_t d2;
		digit_t d3;
	} screen_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               func = FUNC_UPDATE;
	logic [31:0]        tick_now = '0;
	logic signed [15:0] freq_value = '0;
	logic [15:0]        volt_tenths = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	digit_t             digit_code_0;
	digit_t             digit_code_1;
	digit_t             digit_code_2;
	digit_t             digit_code_3;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = REG_BANNER_HOLD;
	logic [15:0]        cfg_data = '0;

	// behavioral copy of the sequencer state
	phase_t      disp_phase = PH_BANNER;
	logic [31:0] disp_start = '0;
	logic [15:0] hold_banner = BANNER_HOLD_RST;
	logic [15:0] hold_freq = FREQ_HOLD_RST;
	logic [15:0] hold_volt = VOLT_HOLD_RST;

	screen_t screen_q[$];
	int      err_count = 0;
	int      burst_left = 0;
	int      ready_cyc = 0;

	freq_volt_display_sequencer DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.tick_now    (tick_now),
		.freq_value  (freq_value),
		.volt_tenths (volt_tenths),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digit_code_0(digit_code_0),
		.digit_code_1(digit_code_1),
		.digit_code_2(digit_code_2),
		.digit_code_3(digit_code_3),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] phase_hold(phase_t ph);
		if (ph == PH_FREQ)
			return hold_freq;
		else if (ph == PH_VOLT)
			return hold_volt;
		return hold_banner;
	endfunction

	function automatic screen_t three_digits(digit_t lead, int unsigned v, digit_t mid_add);
		screen_t s;
		s.d0 = lead;
		s.d1 = digit_t'((v / 100) % 10);
		s.d2 = digit_t'((v / 10) % 10 + mid_add);
		s.d3 = digit_t'(v % 10);
		return s;
	endfunction

	// applies one accepted item to the copy and queues the screen it shows
	task automatic display_step(input logic fn, input logic [31:0] tk,
			input logic signed [15:0] fq, input logic [15:0] vt);
		int unsigned f_shown;
		int unsigned v_shown;
		screen_t     scr;
		phase_t      nxt;
		logic [31:0] elapsed;
		if (fn == FUNC_RESTART) begin
			disp_phase = PH_BANNER;
			disp_start = tk;
			return;
		end
		if (fq < 16'sd0)
			f_shown = 0;
		else
			f_shown = (fq > 16'sd999) ? 32'd999 : 32'(fq);
		v_shown = (vt > {6'd0, DISP_MAX}) ? 32'(DISP_MAX) : 32'(vt);
		if (disp_phase == PH_FREQ) begin
			scr = three_digits(CODE_F, f_shown, 5'd0);
			nxt = PH_VOLT;
		end else if (disp_phase == PH_VOLT) begin
			scr = three_digits(CODE_U, v_shown, CODE_POINT);
			nxt = PH_FREQ;
		end else begin
			scr = '{CODE_DASH, CODE_THREE, CODE_DASH, CODE_DASH};
			nxt = PH_FREQ;
		end
		elapsed = tk - disp_start;
		if (elapsed >= {16'd0, phase_hold(disp_phase)}) begin
			disp_phase = nxt;
			disp_start = tk;
		end
		screen_q.push_back(scr);
	endtask

	task automatic send_item(input logic fn, input logic [31:0] tk,
			input logic signed [15:0] fq, input logic [15:0] vt);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		end else begin
			gap = 0;
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		func        <= fn;
		tick_now    <= tk;
		freq_value  <= fq;
		volt_tenths <= vt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		display_step(fn, tk, fq, vt);
	endtask

	task automatic write_hold(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_BANNER_HOLD)
			hold_banner = val;
		else if (idx == REG_FREQ_HOLD)
			hold_freq = val;
		else if (idx == REG_VOLT_HOLD)
			hold_volt = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop sending and let every screen and any restart leave the block
	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (screen_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	always @(negedge clk) begin
		ready_cyc++;
		case ((ready_cyc / 256) % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 1) == 1);
			2: out_ready <= (ready_cyc % 5) != 0;
			default: out_ready <= (ready_cyc % 16) >= 10;
		endcase
	end

	task automatic check_digit(input string name, input digit_t want, input digit_t got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin : screen_check
		screen_t want;
		if (arst_n && out_valid && out_ready) begin
			if (screen_q.size() == 0) begin
				$display("%0t: screen with nothing expected, actual %0d %0d %0d %0d",
					$time, digit_code_0, digit_code_1, digit_code_2, digit_code_3);
				err_count++;
			end else begin
				want = screen_q.pop_front();
				check_digit("digit_code_0", want.d0, digit_code_0);
				check_digit("digit_code_1", want.d1, digit_code_1);
				check_digit("digit_code_2", want.d2, digit_code_2);
				check_digit("digit_code_3", want.d3, digit_code_3);
			end
		end
	end

	// reset hold values, every phase, clamping edges and a wrapped restart
	task automatic test_directed;
		send_item(FUNC_UPDATE, 32'd0, 16'sd5, 16'd7);
		send_item(FUNC_UPDATE, 32'd199, 16'sd5, 16'd7);
		send_item(FUNC_UPDATE, 32'd200, 16'sd5, 16'd7);
		send_item(FUNC_UPDATE, 32'd300, -16'sd32768, 16'd7);
		send_item(FUNC_UPDATE, 32'd400, -16'sd1, 16'd7);
		send_item(FUNC_UPDATE, 32'd599, 16'sd999, 16'd7);
		send_item(FUNC_UPDATE, 32'd600, 16'sd1000, 16'd7);
		send_item(FUNC_UPDATE, 32'd700, 16'sd0, 16'd0);
		send_item(FUNC_UPDATE, 32'd800, 16'sd0, 16'd999);
		send_item(FUNC_UPDATE, 32'd1000, 16'sd0, 16'd1000);
		send_item(FUNC_UPDATE, 32'd1100, 16'sd32767, 16'd65535);
		send_item(FUNC_RESTART, 32'd1200, 16'sd1, 16'd1);
		send_item(FUNC_UPDATE, 32'd1300, 16'sd42, 16'd65535);
		send_item(FUNC_RESTART, 32'hFFFF_FFF0, 16'sd0, 16'd0);
		send_item(FUNC_UPDATE, 32'h0000_00B7, 16'sd123, 16'd456);
		send_item(FUNC_UPDATE, 32'h0000_00B8, 16'sd123, 16'd456);
		send_item(FUNC_UPDATE, 32'h0000_0100, 16'sd123, 16'd456);
		send_item(FUNC_UPDATE, 32'h0000_0248, 16'sd123, 16'd456);
		send_item(FUNC_UPDATE, 32'h0000_0300, 16'sd123, 16'd509);
		send_item(FUNC_UPDATE, 32'hFFFF_FFFF, -16'sd300, 16'd1);
		drain();
	endtask

	// zero holds: each update shows its phase and moves on
	task automatic test_zero_hold;
		int i;
		write_hold(REG_BANNER_HOLD, 16'd0);
		write_hold(REG_FREQ_HOLD, 16'd0);
		write_hold(REG_VOLT_HOLD, 16'd0);
		for (i = 0; i < 14; i++) begin
			if (i == 7)
				send_item(FUNC_RESTART, 32'd77, 16'sd0, 16'd0);
			send_item(FUNC_UPDATE, 32'd77, 16'($urandom), 16'($urandom));
		end
		drain();
	endtask

	// largest holds across the 32-bit tick wrap
	task automatic test_max_hold_wrap;
		logic [31:0] base;
		write_hold(REG_BANNER_HOLD, 16'hFFFF);
		write_hold(REG_FREQ_HOLD, 16'hFFFF);
		write_hold(REG_VOLT_HOLD, 16'hFFFF);
		base = 32'hFFFF_8000;
		send_item(FUNC_RESTART, base, 16'sd0, 16'd0);
		send_item(FUNC_UPDATE, base + 32'd65534, 16'sd321, 16'd654);
		send_item(FUNC_UPDATE, base + 32'd65535, 16'sd321, 16'd654);
		base = base + 32'd65535;
		send_item(FUNC_UPDATE, base + 32'd65534, 16'sd321, 16'd654);
		send_item(FUNC_UPDATE, base + 32'd65535, 16'sd321, 16'd654);
		base = base + 32'd65535;
		send_item(FUNC_UPDATE, base + 32'd100, 16'sd321, 16'd654);
		send_item(FUNC_UPDATE, base + 32'd65535, 16'sd321, 16'd654);
		send_item(FUNC_UPDATE, base + 32'd65536, 16'sd321, 16'd654);
		drain();
	endtask

	function automatic logic [15:0] pick_hold();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(0, 16));
			4: return 16'($urandom_range(0, 400));
			default: return 16'($urandom);
		endcase
	endfunction

	// running tick sequences under several hold settings, with noise
	task automatic test_random_sequences;
		int          set_idx;
		int          n;
		int          sel;
		int unsigned top_hold;
		logic [31:0] tick_cursor;
		logic signed [15:0] fq;
		logic [15:0] vt;
		for (set_idx = 0; set_idx < 8; set_idx++) begin
			write_hold(REG_BANNER_HOLD, pick_hold());
			write_hold(REG_FREQ_HOLD, pick_hold());
			write_hold(REG_VOLT_HOLD, pick_hold());
			top_hold = 32'(hold_banner);
			if (32'(hold_freq) > top_hold)
				top_hold = 32'(hold_freq);
			if (32'(hold_volt) > top_hold)
				top_hold = 32'(hold_volt);
			tick_cursor = $urandom;
			for (n = 0; n < 210; n++) begin
				if ($urandom_range(0, 3) == 0)
					fq = 16'($urandom);
				else
					fq = 16'($urandom_range(0, 1100));
				if ($urandom_range(0, 3) == 0)
					vt = 16'($urandom);
				else
					vt = 16'($urandom_range(0, 1100));
				sel = $urandom_range(0, 31);
				if (sel < 2) begin
					send_item(FUNC_RESTART, tick_cursor, fq, vt);
				end else if (sel < 4) begin
					// tick jump out of sequence
					send_item(FUNC_UPDATE, $urandom, fq, vt);
				end else if (sel < 9) begin
					// land just on or just short of the hold boundary
					tick_cursor = disp_start + {16'd0, phase_hold(disp_phase)}
						- 32'($urandom_range(0, 1));
					send_item(FUNC_UPDATE, tick_cursor, fq, vt);
				end else begin
					tick_cursor = tick_cursor + $urandom_range(0, top_hold / 3 + 2);
					send_item(FUNC_UPDATE, tick_cursor, fq, vt);
				end
			end
			drain();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_zero_hold();
		test_max_hold_wrap();
		test_random_sequences();
		@(negedge clk);
		in_valid <= 1'b0;
		while (screen_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0 && screen_q.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout, %0d screens still expected", $time, screen_q.size());
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
